### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hw/rtl/lrs_pkg.sv
// types and constants of the labeled region statistics block
package lrs_pkg;

    localparam int LABEL_BITS     = 11;
    localparam int VALUE_BITS     = 16;
    localparam int COUNT_BITS     = 20;
    localparam int SUM_BITS       = COUNT_BITS + VALUE_BITS;
    localparam int MAX_LABELS_DEF = 1024;

    localparam logic signed [VALUE_BITS-1:0] BAD_VALUE_RST = -16'sd9999;

    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic [LABEL_BITS-1:0]        label;
        logic signed [VALUE_BITS-1:0] value;
        logic signed [VALUE_BITS-1:0] companion;
    } lrs_in_t;

    typedef struct packed {
        logic [LABEL_BITS-1:0]        out_label;
        logic [COUNT_BITS-1:0]        pixel_count;
        logic signed [VALUE_BITS-1:0] mean_value;
        logic signed [VALUE_BITS-1:0] min_value;
        logic signed [VALUE_BITS-1:0] max_value;
        logic signed [VALUE_BITS-1:0] companion_at_min;
        logic                         is_empty;
        logic                         count_saturated;
    } lrs_out_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]        count;
        logic signed [SUM_BITS-1:0]   sum;
        logic signed [VALUE_BITS-1:0] minv;
        logic signed [VALUE_BITS-1:0] maxv;
        logic signed [VALUE_BITS-1:0] comp;
        logic                         ovf;
    } lrs_rec_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lrs_div_stat_t;

endpackage

### hw/rtl/lrs_div.sv
// sequential signed divider for the region mean, one quotient bit per cycle
`include "assert_macros.svh"

module lrs_div
    import lrs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0]      divisor,
    input  logic                       take,
    output lrs_div_stat_t              stat,
    output logic signed [SUM_BITS-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [SUM_BITS-1:0]   quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic                  neg_reg;
    logic [STEP_W-1:0]     step_reg;

    logic [COUNT_BITS:0]   shifted;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        quo_reg   <= dividend[SUM_BITS-1] ? -dividend : dividend;
                        neg_reg   <= dividend[SUM_BITS-1];
                        rem_reg   <= '0;
                        dvs_reg   <= divisor;
                        step_reg  <= STEP_W'(SUM_BITS - 1);
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    rem_reg <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
                    quo_reg <= {quo_reg[SUM_BITS-2:0], fits};
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = state_reg != ST_IDLE;
    assign stat.done = state_reg == ST_DONE;
    assign quotient  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    `ASSERT_CLK(a_start_when_idle, start |-> state_reg == ST_IDLE, "divider started while busy")
    `ASSERT_CLK(a_take_when_done, take |-> state_reg == ST_DONE, "quotient taken before done")

endmodule

### hw/rtl/labeled_region_statistics.sv
// top level of the labeled region statistics block
// Per-label statistics engine. Each label 1..MAX_LABELS has one entry in a single
// synchronous memory (count, sum, min, max, companion at min, overflow flag) that is
// read, updated and written back. Accumulate transfers are taken one per cycle unless
// the clearing pass or a read request holds them off; a transfer that hits the entry
// written in the same cycle is served by a forwarding register. A read request returns
// the entry and clears it; the mean is formed by a one-bit-per-cycle divider, so a read
// request holds off the request channel while the divider is busy, including any wait
// for the response slot. After reset a clearing pass writes every entry, one per cycle,
// and no request is taken until it has finished. The bad_value register may be written
// at any time but should only change while no request is in flight.
`include "assert_macros.svh"

module labeled_region_statistics
    import lrs_pkg::*;
#(
    parameter int MAX_LABELS = MAX_LABELS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [VALUE_BITS-1:0] cfg_wr_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  lrs_in_t               req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output lrs_out_t              rsp_data
);

    localparam int ADDR_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(MAX_LABELS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    lrs_rec_t mem [MAX_LABELS];

    logic signed [VALUE_BITS-1:0] bad_value_reg;

    logic                  clear_active_reg, clear_active_next;
    logic [ADDR_W-1:0]     clear_addr_reg, clear_addr_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_req_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [LABEL_BITS-1:0] s1_label_reg;
    logic signed [VALUE_BITS-1:0] s1_value_reg;
    logic signed [VALUE_BITS-1:0] s1_comp_reg;

    logic                  fwd_reg, fwd_next;
    lrs_rec_t              fwd_data_reg;
    lrs_rec_t              rd_data_reg;
    lrs_rec_t              cur_rec;
    lrs_rec_t              upd_rec;

    logic                  req_acc;
    logic                  lbl_ok;
    logic [LABEL_BITS-1:0] lbl_idx;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  item_live;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    lrs_rec_t              wr_data;

    logic signed [SUM_BITS-1:0] val_ext;

    logic                  div_start;
    logic                  div_take;
    lrs_div_stat_t         div_stat;
    logic signed [SUM_BITS-1:0] div_quotient;

    logic [LABEL_BITS-1:0] pend_label_reg;
    lrs_rec_t              pend_rec_reg;

    logic                  rsp_valid_reg, rsp_valid_next;
    lrs_out_t              rsp_data_reg, rsp_data_next;

    // request side
    assign req_acc   = req_valid && !req_stall;
    assign lbl_ok    = (req_data.label != '0) && (32'(req_data.label) <= 32'(MAX_LABELS));
    assign lbl_idx   = req_data.label - LABEL_BITS'(1);
    assign rd_addr   = ADDR_W'(lbl_idx);
    assign item_live = req_acc && lbl_ok &&
                       ((req_data.req_type == REQ_READ) || (req_data.value != bad_value_reg));

    assign div_start = s1_valid_reg && (s1_req_reg == REQ_READ);
    assign req_stall = clear_active_reg || div_start || div_stat.busy;

    // read-modify-write of the label entry
    assign cur_rec = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign val_ext = {{(SUM_BITS-VALUE_BITS){s1_value_reg[VALUE_BITS-1]}}, s1_value_reg};

    always_comb
    begin
        upd_rec = cur_rec;
        if (s1_req_reg == REQ_READ)
        begin
            upd_rec = '0;
        end
        else if (cur_rec.count == CNT_MAX)
        begin
            upd_rec.ovf = 1'b1;
        end
        else if (cur_rec.count == '0)
        begin
            upd_rec.count = COUNT_BITS'(1);
            upd_rec.sum   = val_ext;
            upd_rec.minv  = s1_value_reg;
            upd_rec.maxv  = s1_value_reg;
            upd_rec.comp  = s1_comp_reg;
            upd_rec.ovf   = 1'b0;
        end
        else
        begin
            upd_rec.count = cur_rec.count + COUNT_BITS'(1);
            upd_rec.sum   = cur_rec.sum + val_ext;
            if (s1_value_reg < cur_rec.minv)
            begin
                upd_rec.minv = s1_value_reg;
                upd_rec.comp = s1_comp_reg;
            end
            if (s1_value_reg > cur_rec.maxv)
            begin
                upd_rec.maxv = s1_value_reg;
            end
        end
    end

    assign wr_en   = clear_active_reg || s1_valid_reg;
    assign wr_addr = clear_active_reg ? clear_addr_reg : s1_addr_reg;
    assign wr_data = clear_active_reg ? '0 : upd_rec;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (item_live)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control next state
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg)
        begin
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_active_next = 1'b0;
            end
            else
            begin
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
            end
        end
        s1_valid_next = item_live;
        fwd_next      = item_live && s1_valid_reg && (s1_addr_reg == rd_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_value_reg    <= BAD_VALUE_RST;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bad_value_reg <= cfg_wr_data;
            end
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            s1_valid_reg     <= s1_valid_next;
            fwd_reg          <= fwd_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_live)
        begin
            s1_req_reg   <= req_data.req_type;
            s1_addr_reg  <= rd_addr;
            s1_label_reg <= req_data.label;
            s1_value_reg <= req_data.value;
            s1_comp_reg  <= req_data.companion;
        end
        if (fwd_next)
        begin
            fwd_data_reg <= upd_rec;
        end
        if (div_start)
        begin
            pend_label_reg <= s1_label_reg;
            pend_rec_reg   <= cur_rec;
        end
        if (div_take)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    // mean of the entry being read
    lrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cur_rec.sum),
        .divisor  (cur_rec.count),
        .take     (div_take),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // response slot
    assign div_take = div_stat.done && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (div_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_data_next.out_label = pend_label_reg;
        if (pend_rec_reg.count == '0)
        begin
            rsp_data_next.pixel_count      = '0;
            rsp_data_next.mean_value       = bad_value_reg;
            rsp_data_next.min_value        = bad_value_reg;
            rsp_data_next.max_value        = bad_value_reg;
            rsp_data_next.companion_at_min = bad_value_reg;
            rsp_data_next.is_empty         = 1'b1;
            rsp_data_next.count_saturated  = 1'b0;
        end
        else
        begin
            rsp_data_next.pixel_count      = pend_rec_reg.count;
            rsp_data_next.mean_value       = div_quotient[VALUE_BITS-1:0];
            rsp_data_next.min_value        = pend_rec_reg.minv;
            rsp_data_next.max_value        = pend_rec_reg.maxv;
            rsp_data_next.companion_at_min = pend_rec_reg.comp;
            rsp_data_next.is_empty         = 1'b0;
            rsp_data_next.count_saturated  = pend_rec_reg.ovf;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    `ASSERT_NEVER(a_no_write_collision, clear_active_reg && s1_valid_reg, "update during clear pass")
    `ASSERT_CLK(a_div_start_idle, div_start |-> !div_stat.busy, "read request while divider busy")
    `ASSERT_CLK(a_rsp_from_div, $rose(rsp_valid_reg) |-> $past(div_stat.done), "response without mean")
    `ASSERT_CLK(a_fwd_after_update, fwd_reg |-> $past(s1_valid_reg), "forward without prior update")

endmodule
